// ----- src/kmeg_pkg.sv -----
// ----------------------------------------------------------------------------
// kmeg_pkg: shared types and constants
// Field widths, register codes, event codes and the per-key state word of
// the key matrix event generator.
// ----------------------------------------------------------------------------
package kmeg_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLUMNS = 8;
    localparam int KEY_COUNT   = 64;
    localparam int KEY_W       = $clog2(KEY_COUNT);

    localparam int COL_W      = 3;
    localparam int ROWS_W     = 8;
    localparam int CNT_W      = 4;
    localparam int BTN_W      = 7;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT      = 3'd0,
        CFG_COLUMN_COUNT   = 3'd1,
        CFG_BUTTON_COUNT   = 3'd2,
        CFG_INITIAL_DELAY  = 3'd3,
        CFG_REPEAT_RATE    = 3'd4,
        CFG_PRESS_ENABLE   = 3'd5,
        CFG_RELEASE_ENABLE = 3'd6,
        CFG_HOLD_ENABLE    = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_HOLD    = 2'd2
    } t_event_kind;

    // per-key word kept in the state RAM
    typedef struct packed {
        logic                down;
        logic                phase;   // set: count holds the repeat phase
        logic [DELAY_W-1:0]  count;
    } t_key_state;

    localparam int STATE_W = $bits(t_key_state);

    localparam logic [CNT_W-1:0]   RST_ROW_COUNT     = 4'd8;
    localparam logic [CNT_W-1:0]   RST_COLUMN_COUNT  = 4'd8;
    localparam logic [BTN_W-1:0]   RST_BUTTON_COUNT  = 7'd64;
    localparam logic [DELAY_W-1:0] RST_INITIAL_DELAY = 16'd10;
    localparam logic [DELAY_W-1:0] RST_REPEAT_RATE   = 16'd5;

    localparam t_key_state KEY_RESET_STATE = '{
        down:  1'b0,
        phase: 1'b0,
        count: RST_INITIAL_DELAY
    };

endpackage

// ----- src/kmeg_if.sv -----
// ----------------------------------------------------------------------------
// kmeg channels
// Valid/ready channels for column beats, event beats and register writes.
// ----------------------------------------------------------------------------
interface kmeg_in_if;
    logic                        valid;
    logic                        ready;
    logic [kmeg_pkg::COL_W-1:0]  column_index;
    logic [kmeg_pkg::ROWS_W-1:0] row_bits;
    logic                        locked;

    modport source (output valid, column_index, row_bits, locked, input ready);
    modport sink   (input valid, column_index, row_bits, locked, output ready);
endinterface

interface kmeg_out_if;
    logic                       valid;
    logic                       ready;
    logic [kmeg_pkg::KEY_W-1:0] key_index;
    kmeg_pkg::t_event_kind      event_kind;
    logic                       last_event;

    modport source (output valid, key_index, event_kind, last_event, input ready);
    modport sink   (input valid, key_index, event_kind, last_event, output ready);
endinterface

interface kmeg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kmeg_pkg::CFG_IDX_W-1:0]  index;
    logic [kmeg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/kmeg_ram.sv -----
// ----------------------------------------------------------------------------
// kmeg_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, read-before-write.
// ----------------------------------------------------------------------------
module kmeg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

// ----- src/keypad_matrix_event_generator_core.sv -----
// ----------------------------------------------------------------------------
// keypad_matrix_event_generator_core
// Key matrix scanner back end: per-key pressed flag and auto-repeat counter
// in a RAM, press/release/hold events emitted in key order.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat                                     handshake
//  --------  ---  ---------------------------------------  -----------
//  i_item    in   column_index, row_bits, locked           valid/ready
//  o_event   out  key_index, event_kind, last_event        valid/ready
//  i_cfg     in   index, data (register write)             valid/ready
//
//  One key per cycle unless o_event stalls: a column beat walks its keys in
//  range (1..8) in a single read-modify-write pass over the state RAM.
//  The next column beat is taken in the cycle its predecessor issues its
//  last key, so full columns stream back to back. An event passes the RAM
//  read, then the pending slot and the output reg; it waits in the pending
//  slot until a later key of its column fires or the column's last key is
//  done. Reset: synchronous; per-entry valid flops stand in for clearing
//  the RAM, so the block takes beats as soon as reset is released.
//  A stalled o_event freezes the key pipeline; i_item is still taken while
//  the sequencer is free.
//
module keypad_matrix_event_generator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kmeg_in_if.sink          i_item,
    kmeg_out_if.source       o_event,
    kmeg_cfg_if.sink         i_cfg
);
    import kmeg_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]     r_row_count;
    logic [CNT_W-1:0]     r_column_count;
    logic [BTN_W-1:0]     r_button_count;
    logic [DELAY_W-1:0]   r_initial_delay;
    logic [DELAY_W-1:0]   r_repeat_rate;
    logic [KEY_COUNT-1:0] r_press_en;
    logic [KEY_COUNT-1:0] r_release_en;
    logic [KEY_COUNT-1:0] r_hold_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= RST_ROW_COUNT;
            r_column_count  <= RST_COLUMN_COUNT;
            r_button_count  <= RST_BUTTON_COUNT;
            r_initial_delay <= RST_INITIAL_DELAY;
            r_repeat_rate   <= RST_REPEAT_RATE;
            r_press_en      <= '0;
            r_release_en    <= '0;
            r_hold_en       <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_ROW_COUNT:      r_row_count     <= i_cfg.data[CNT_W-1:0];
                CFG_COLUMN_COUNT:   r_column_count  <= i_cfg.data[CNT_W-1:0];
                CFG_BUTTON_COUNT:   r_button_count  <= i_cfg.data[BTN_W-1:0];
                CFG_INITIAL_DELAY:  r_initial_delay <= i_cfg.data[DELAY_W-1:0];
                CFG_REPEAT_RATE:    r_repeat_rate   <= i_cfg.data[DELAY_W-1:0];
                CFG_PRESS_ENABLE:   r_press_en      <= i_cfg.data[KEY_COUNT-1:0];
                CFG_RELEASE_ENABLE: r_release_en    <= i_cfg.data[KEY_COUNT-1:0];
                CFG_HOLD_ENABLE:    r_hold_en       <= i_cfg.data[KEY_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // effective counts, clamped to the matrix size
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [BTN_W-1:0] nbut_eff;

    assign rows_eff = (r_row_count > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_row_count;
    assign cols_eff = (r_column_count > CNT_W'(MAX_COLUMNS)) ?
                      CNT_W'(MAX_COLUMNS) : r_column_count;
    assign nbut_eff = (r_button_count > BTN_W'(KEY_COUNT)) ?
                      BTN_W'(KEY_COUNT) : r_button_count;

    // pipeline advance: the key pipeline moves only when the output can take a beat
    logic r_o_valid;
    logic en;
    assign en = !r_o_valid || o_event.ready;

    // ------------------------------------------------------------------
    // sequencer: walks the rows of the current column while o_event does not stall, one key per cycle
    // ------------------------------------------------------------------
    logic                       r_busy;
    logic [BTN_W-1:0]           r_base;
    logic [$clog2(MAX_ROWS)-1:0] r_row;
    logic [ROWS_W-1:0]          r_bits;
    logic                       r_locked;

    logic [BTN_W-1:0] in_base;
    logic             in_has_work;
    logic [BTN_W-1:0] cur_key;
    logic             cur_last;
    logic             issue;
    logic             in_accept;

    assign in_base     = BTN_W'(i_item.column_index) * BTN_W'(rows_eff);
    assign in_has_work = (CNT_W'(i_item.column_index) < cols_eff) && (rows_eff != '0)
                      && (in_base < nbut_eff);

    assign cur_key  = r_base + BTN_W'(r_row);
    assign cur_last = ((CNT_W'(r_row) + CNT_W'(1)) >= rows_eff)
                   || ((cur_key + BTN_W'(1)) >= nbut_eff);
    assign issue    = r_busy && en;

    assign i_item.ready = !r_busy || (issue && cur_last);
    assign in_accept    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_accept) begin
            r_busy <= in_has_work;
        end else if (issue && cur_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_base   <= in_base;
            r_row    <= '0;
            r_bits   <= i_item.row_bits;
            r_locked <= i_item.locked;
        end else if (issue) begin
            r_row    <= r_row + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // state RAM with per-entry valid flops (unwritten entry = reset state)
    // ------------------------------------------------------------------
    logic [KEY_COUNT-1:0] r_entry_valid;
    logic [STATE_W-1:0]   rd_data;
    t_key_state           n_state;

    logic             r_b_valid;
    logic [KEY_W-1:0] r_b_key;
    logic             r_b_now;
    logic             r_b_locked;
    logic             r_b_last;
    logic             r_b_init;

    // last write, for the read issued in the same cycle as that write
    logic             r_wr_valid;
    logic [KEY_W-1:0] r_wr_addr;
    t_key_state       r_wr_data;

    kmeg_ram #(
        .WIDTH (STATE_W),
        .DEPTH (KEY_COUNT)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (en && r_b_valid),
        .i_wr_addr (r_b_key),
        .i_wr_data (n_state),
        .i_rd_en   (issue),
        .i_rd_addr (cur_key[KEY_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_b_valid     <= 1'b0;
            r_wr_valid    <= 1'b0;
        end else if (en) begin
            if (r_b_valid) begin
                r_entry_valid[r_b_key] <= 1'b1;
            end
            r_b_valid  <= issue;
            r_wr_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_key    <= cur_key[KEY_W-1:0];
            r_b_now    <= r_bits[r_row];
            r_b_locked <= r_locked;
            r_b_last   <= cur_last;
            r_b_init   <= r_entry_valid[cur_key[KEY_W-1:0]];
            r_wr_addr  <= r_b_key;
            r_wr_data  <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // key update
    // ------------------------------------------------------------------
    logic        ev_fire;
    t_event_kind ev_kind;

    always_comb begin
        t_key_state       cur;
        logic             pe;
        logic             re;
        logic             he;
        logic [DELAY_W:0] inc;

        if (r_wr_valid && (r_wr_addr == r_b_key)) begin
            cur = r_wr_data;
        end else if (r_b_init) begin
            cur = t_key_state'(rd_data);
        end else begin
            cur = KEY_RESET_STATE;
        end
        pe  = r_press_en[r_b_key];
        re  = r_release_en[r_b_key];
        he  = r_hold_en[r_b_key];
        inc = {1'b0, cur.count} + 1'b1;

        n_state = cur;
        ev_fire = 1'b0;
        ev_kind = EV_PRESS;

        if (r_b_locked) begin
            n_state.down = r_b_now;
        end else if (cur.down != r_b_now) begin
            n_state.down = r_b_now;
            if (r_b_now && pe) begin
                if (he) begin
                    n_state.phase = 1'b0;
                    n_state.count = r_initial_delay;
                end
                ev_fire = 1'b1;
                ev_kind = EV_PRESS;
            end else if (!r_b_now && re) begin
                n_state.phase = 1'b0;
                n_state.count = r_initial_delay;
                ev_fire = 1'b1;
                ev_kind = EV_RELEASE;
            end
        end else if (r_b_now && he) begin
            ev_kind = EV_HOLD;
            if (!cur.phase && (cur.count > DELAY_W'(1))) begin
                n_state.count = cur.count - 1'b1;
            end else if (!cur.phase && (cur.count == DELAY_W'(1))) begin
                n_state.phase = 1'b1;
                n_state.count = '0;
                ev_fire = 1'b1;
            end else begin
                // repeat phase; a spent countdown of zero in phase zero also steps here
                n_state.phase = 1'b1;
                if (inc >= {1'b0, r_repeat_rate}) begin
                    n_state.count = '0;
                    ev_fire = 1'b1;
                end else begin
                    n_state.count = inc[DELAY_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // event ordering: one pending event is held back until it is known
    // whether a later key of the same column fires, which sets last_event
    // ------------------------------------------------------------------
    logic             r_p_valid;
    logic [KEY_W-1:0] r_p_key;
    t_event_kind      r_p_kind;
    logic             r_p_final;

    logic [KEY_W-1:0] r_o_key;
    t_event_kind      r_o_kind;
    logic             r_o_last;

    logic ev;
    logic col_end;
    logic push;
    logic push_last;

    assign ev        = r_b_valid && ev_fire;
    assign col_end   = r_b_valid && r_b_last;
    assign push      = en && r_p_valid && (r_p_final || ev || col_end);
    assign push_last = r_p_final || (col_end && !ev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en && ev) begin
                r_p_valid <= 1'b1;
            end else if (push) begin
                r_p_valid <= 1'b0;
            end
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (o_event.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && ev) begin
            r_p_key   <= r_b_key;
            r_p_kind  <= ev_kind;
            r_p_final <= r_b_last;
        end
        if (push) begin
            r_o_key  <= r_p_key;
            r_o_kind <= r_p_kind;
            r_o_last <= push_last;
        end
    end

    assign o_event.valid      = r_o_valid;
    assign o_event.key_index  = r_o_key;
    assign o_event.event_kind = r_o_kind;
    assign o_event.last_event = r_o_last;

endmodule
